[src/ksl_pkg.sv]
// Shared operation codes, record layout and item types for the keyed slot table.
package ksl_pkg;

  localparam logic [2:0] OP_ADD       = 3'd0;
  localparam logic [2:0] OP_MODIFY    = 3'd1;
  localparam logic [2:0] OP_DELETE    = 3'd2;
  localparam logic [2:0] OP_FIND_ITEM = 3'd3;
  localparam logic [2:0] OP_FIND_OBJ  = 3'd4;
  localparam logic [2:0] OP_CLEAR     = 3'd5;

  localparam int KEY_W  = 64;
  localparam int DATA_W = 192;

  typedef struct packed {
    logic [2:0]         operation;
    logic [31:0]        object_id;
    logic [31:0]        item_id;
    logic [63:0]        quantity;
    logic [15:0]        kind_one;
    logic [15:0]        kind_two;
    logic signed [31:0] location;
    logic [15:0]        equipped;
    logic [15:0]        enchant;
    logic signed [31:0] mana;
  } cmd_t;

  typedef struct packed {
    logic               hit;
    logic [7:0]         slot_index;
    logic [8:0]         used_slots;
    logic [31:0]        rec_object_id;
    logic [31:0]        rec_item_id;
    logic [63:0]        rec_quantity;
    logic [15:0]        rec_kind_one;
    logic [15:0]        rec_kind_two;
    logic signed [31:0] rec_location;
    logic [15:0]        rec_equipped;
    logic [15:0]        rec_enchant;
    logic signed [31:0] rec_mana;
  } rsp_t;

  // Handshake between the top level and the table engine.
  typedef struct packed {
    logic start;
    logic out_free;
  } eng_ctl_t;

  typedef struct packed {
    logic ready;
    logic done;
  } eng_sts_t;

endpackage

[src/ksl_req_if.sv]
// Request channel interface: one table operation per item.
interface ksl_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [31:0]        object_id;
  logic [31:0]        item_id;
  logic [63:0]        quantity;
  logic [15:0]        kind_one;
  logic [15:0]        kind_two;
  logic signed [31:0] location;
  logic [15:0]        equipped;
  logic [15:0]        enchant;
  logic signed [31:0] mana;

  modport source (
    output valid, operation, object_id, item_id, quantity, kind_one, kind_two,
           location, equipped, enchant, mana,
    input  ready
  );
  modport sink (
    input  valid, operation, object_id, item_id, quantity, kind_one, kind_two,
           location, equipped, enchant, mana,
    output ready
  );
endinterface

[src/ksl_rsp_if.sv]
// Response channel interface: one result item per operation.
interface ksl_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [7:0]         slot_index;
  logic [8:0]         used_slots;
  logic [31:0]        rec_object_id;
  logic [31:0]        rec_item_id;
  logic [63:0]        rec_quantity;
  logic [15:0]        rec_kind_one;
  logic [15:0]        rec_kind_two;
  logic signed [31:0] rec_location;
  logic [15:0]        rec_equipped;
  logic [15:0]        rec_enchant;
  logic signed [31:0] rec_mana;

  modport source (
    output valid, hit, slot_index, used_slots, rec_object_id, rec_item_id,
           rec_quantity, rec_kind_one, rec_kind_two, rec_location,
           rec_equipped, rec_enchant, rec_mana,
    input  ready
  );
  modport sink (
    input  valid, hit, slot_index, used_slots, rec_object_id, rec_item_id,
           rec_quantity, rec_kind_one, rec_kind_two, rec_location,
           rec_equipped, rec_enchant, rec_mana,
    output ready
  );
endinterface

[src/keyed_slot_table.sv]
// Top level of the keyed slot table: channel handshakes and the result register.
//
//   channel   | direction | payload
//   ----------+-----------+---------------------------------------------
//   request   | in        | operation, two ids and the record fields
//   response  | out       | hit, slot_index, used_slots, rec_* fields
//
// Add, modify, delete and find scan the key memory one slot per cycle; the
// scan stops at the first match.
// Clear sweeps the key memory at one slot per cycle.
// After reset the same sweep runs over every slot before the first item.
// The result register lets the next item enter while a result waits.
module keyed_slot_table #(
  parameter int ENTRIES = 256
) (
  input  logic    clk,
  input  logic    rst,
  ksl_req_if.sink   request,
  ksl_rsp_if.source response
);

  ksl_pkg::cmd_t     cmd;
  ksl_pkg::rsp_t     rsp;
  ksl_pkg::rsp_t     rsp_reg;
  ksl_pkg::eng_ctl_t ctl;
  ksl_pkg::eng_sts_t sts;
  logic              out_valid;

  assign cmd.operation = request.operation;
  assign cmd.object_id = request.object_id;
  assign cmd.item_id   = request.item_id;
  assign cmd.quantity  = request.quantity;
  assign cmd.kind_one  = request.kind_one;
  assign cmd.kind_two  = request.kind_two;
  assign cmd.location  = request.location;
  assign cmd.equipped  = request.equipped;
  assign cmd.enchant   = request.enchant;
  assign cmd.mana      = request.mana;

  assign request.ready = sts.ready;
  assign ctl.start     = request.valid && sts.ready;
  assign ctl.out_free  = !out_valid || response.ready;

  ksl_engine #(.ENTRIES(ENTRIES)) u_engine (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .cmd_in (cmd),
    .sts    (sts),
    .rsp    (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sts.done && ctl.out_free) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.done && ctl.out_free) begin
      rsp_reg <= rsp;
    end
  end

  assign response.valid         = out_valid;
  assign response.hit           = rsp_reg.hit;
  assign response.slot_index    = rsp_reg.slot_index;
  assign response.used_slots    = rsp_reg.used_slots;
  assign response.rec_object_id = rsp_reg.rec_object_id;
  assign response.rec_item_id   = rsp_reg.rec_item_id;
  assign response.rec_quantity  = rsp_reg.rec_quantity;
  assign response.rec_kind_one  = rsp_reg.rec_kind_one;
  assign response.rec_kind_two  = rsp_reg.rec_kind_two;
  assign response.rec_location  = rsp_reg.rec_location;
  assign response.rec_equipped  = rsp_reg.rec_equipped;
  assign response.rec_enchant   = rsp_reg.rec_enchant;
  assign response.rec_mana      = rsp_reg.rec_mana;

endmodule

[src/ksl_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module ksl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/ksl_engine.sv]
// Table engine: key and record memories, slot scan, clearing sweep and counters.
module ksl_engine #(
  parameter int ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  ksl_pkg::eng_ctl_t ctl,
  input  ksl_pkg::cmd_t     cmd_in,
  output ksl_pkg::eng_sts_t sts,
  output ksl_pkg::rsp_t     rsp
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [3:0] {
    ST_SWEEP = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                     state, state_next;
  ksl_pkg::cmd_t              cmd;
  logic [AW:0]                issue_cnt;
  logic                       pend_valid;
  logic [AW-1:0]              pend_addr;
  logic [AW-1:0]              slot;
  logic                       hit;
  logic                       show;
  logic                       sweep_reply;
  logic [CW-1:0]              used_total;
  logic [ksl_pkg::KEY_W-1:0]  found_key;

  logic [ksl_pkg::KEY_W-1:0]  cmd_key;
  logic [ksl_pkg::KEY_W-1:0]  key_rdata;
  logic [ksl_pkg::DATA_W-1:0] data_rdata;
  logic [ksl_pkg::DATA_W-1:0] data_wdata;
  logic                       key_we;
  logic [AW-1:0]              key_waddr;
  logic [ksl_pkg::KEY_W-1:0]  key_wdata;
  logic                       data_we;
  logic                       data_re;
  logic                       key_re;
  logic                       match;
  logic                       found;
  logic                       miss;
  logic                       sweep_last;
  logic                       is_add;
  logic                       is_mod;
  logic                       is_del;
  logic                       is_find;

  assign cmd_key    = {cmd.item_id, cmd.object_id};
  assign data_wdata = {cmd.mana, cmd.enchant, cmd.equipped, cmd.location,
                       cmd.kind_two, cmd.kind_one, cmd.quantity};

  assign is_add  = (cmd.operation == ksl_pkg::OP_ADD);
  assign is_mod  = (cmd.operation == ksl_pkg::OP_MODIFY);
  assign is_del  = (cmd.operation == ksl_pkg::OP_DELETE);
  assign is_find = (cmd.operation == ksl_pkg::OP_FIND_ITEM) ||
                   (cmd.operation == ksl_pkg::OP_FIND_OBJ);

  // Free slots only match an add; every other operation looks at used slots.
  always_comb begin
    case (cmd.operation)
      ksl_pkg::OP_ADD:       match = (key_rdata == '0);
      ksl_pkg::OP_FIND_ITEM: match = (key_rdata != '0) && (key_rdata[63:32] == cmd.item_id);
      ksl_pkg::OP_FIND_OBJ:  match = (key_rdata != '0) && (key_rdata[31:0] == cmd.object_id);
      default:               match = (key_rdata != '0) && (key_rdata == cmd_key);
    endcase
  end

  assign found      = (state == ST_SCAN) && pend_valid && match;
  assign miss       = (state == ST_SCAN) && pend_valid && !match &&
                      (pend_addr == AW'(ENTRIES - 1));
  assign key_re     = (state == ST_SCAN) && !found &&
                      (issue_cnt != (AW + 1)'(ENTRIES));
  assign sweep_last = (issue_cnt[AW-1:0] == AW'(ENTRIES - 1));

  assign key_we    = (state == ST_SWEEP) || (found && (is_add || is_mod || is_del));
  assign key_waddr = (state == ST_SWEEP) ? issue_cnt[AW-1:0] : pend_addr;
  assign key_wdata = ((state == ST_SWEEP) || is_del) ? '0 : cmd_key;
  assign data_we   = found && (is_add || is_mod);
  assign data_re   = found && is_find;

  ksl_ram #(.WIDTH(ksl_pkg::KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .re    (key_re),
    .raddr (issue_cnt[AW-1:0]),
    .rdata (key_rdata)
  );

  ksl_ram #(.WIDTH(ksl_pkg::DATA_W), .DEPTH(ENTRIES)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (pend_addr),
    .wdata (data_wdata),
    .re    (data_re),
    .raddr (pend_addr),
    .rdata (data_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_SWEEP: begin
        if (sweep_last) begin
          state_next = sweep_reply ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (ctl.start) begin
          if (cmd_in.operation == ksl_pkg::OP_CLEAR) begin
            state_next = ST_SWEEP;
          end else if (((cmd_in.operation == ksl_pkg::OP_ADD) &&
                         (cmd_in.object_id == '0) && (cmd_in.item_id == '0)) ||
                       (cmd_in.operation > ksl_pkg::OP_CLEAR)) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (found || miss) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ctl.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      issue_cnt   <= '0;
      pend_valid  <= 1'b0;
      used_total  <= '0;
      sweep_reply <= 1'b0;
      hit         <= 1'b0;
      show        <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_SWEEP: begin
          issue_cnt <= sweep_last ? '0 : issue_cnt + 1'b1;
        end
        ST_IDLE: begin
          issue_cnt   <= '0;
          pend_valid  <= 1'b0;
          hit         <= 1'b0;
          show        <= 1'b0;
          sweep_reply <= 1'b0;
          if (ctl.start && (cmd_in.operation == ksl_pkg::OP_CLEAR)) begin
            sweep_reply <= 1'b1;
            used_total  <= '0;
          end
        end
        ST_SCAN: begin
          pend_valid <= key_re;
          if (key_re) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (found) begin
            hit  <= 1'b1;
            show <= is_find;
            if (is_add) begin
              used_total <= used_total + 1'b1;
            end else if (is_del && (used_total != '0)) begin
              used_total <= used_total - 1'b1;
            end
          end
        end
        ST_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers: command, scan address, and the slot and key of a found record.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && ctl.start) begin
      cmd <= cmd_in;
    end
    if (state == ST_SCAN) begin
      pend_addr <= issue_cnt[AW-1:0];
    end
    if (found) begin
      slot      <= pend_addr;
      found_key <= key_rdata;
    end
  end

  assign sts.ready = (state == ST_IDLE);
  assign sts.done  = (state == ST_DONE);

  always_comb begin
    rsp            = '0;
    rsp.hit        = hit;
    rsp.slot_index = hit ? 8'(slot) : 8'd0;
    rsp.used_slots = 9'(used_total);
    if (show) begin
      rsp.rec_object_id = found_key[31:0];
      rsp.rec_item_id   = found_key[63:32];
      rsp.rec_quantity  = data_rdata[63:0];
      rsp.rec_kind_one  = data_rdata[79:64];
      rsp.rec_kind_two  = data_rdata[95:80];
      rsp.rec_location  = data_rdata[127:96];
      rsp.rec_equipped  = data_rdata[143:128];
      rsp.rec_enchant   = data_rdata[159:144];
      rsp.rec_mana      = data_rdata[191:160];
    end
  end

endmodule
